// ===== design/gce_pkg.sv =====
package gce_pkg;

	localparam int BATCH_WORDS = 1024;
	localparam int NUM_REGS    = 16;
	localparam int REG_AW      = $clog2(NUM_REGS);
	localparam int CNT_W       = $clog2(BATCH_WORDS + 1);
	localparam int WIB_W       = 11;
	localparam int MAX_WORDS   = 6;
	localparam int NW_W        = $clog2(MAX_WORDS + 1);
	localparam int SLOT_W      = $clog2(MAX_WORDS);
	localparam int CFG_IDX_W   = 4;

	typedef enum logic [7:0] {
		OP_ADD  = 8'd200,
		OP_SUB  = 8'd201,
		OP_MUL  = 8'd202,
		OP_MOV  = 8'd206,
		OP_HALT = 8'd212,
		OP_DRAW = 8'd215
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILL_COLOR   = 4'd0,
		CFG_DEFAULT_SIZE = 4'd1
	} cfg_reg_t;

	localparam logic [31:0] WORD_BLIT  = (32'h02 << 22) | 32'h50;
	localparam logic [31:0] WORD_FLUSH = 32'h04;
	localparam logic [31:0] WORD_END   = 32'h0A;

	localparam logic [31:0] FILL_COLOR_RST   = 32'hFF00FF00;
	localparam logic [31:0] DEFAULT_SIZE_RST = 32'd10;

	// One instruction's burst of command words, handed to the output stage.
	typedef struct packed {
		logic                             load;
		logic [NW_W-1:0]                  n;
		logic [MAX_WORDS-1:0][31:0]       words;
		logic [MAX_WORDS-1:0][WIB_W-1:0]  wib;
	} burst_t;

endpackage

// ===== design/gce_if.sv =====
interface gce_instr_if import gce_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [7:0]  opcode;
	logic [7:0]  dest_index;
	logic [7:0]  first_source;
	logic [31:0] second_source;
	logic        program_start;
	logic        program_end;

	modport source (output valid, opcode, dest_index, first_source, second_source,
		program_start, program_end, input ready);
	modport sink (input valid, opcode, dest_index, first_source, second_source,
		program_start, program_end, output ready);
endinterface

interface gce_cmd_if import gce_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [31:0]      command_word;
	logic [WIB_W-1:0] words_in_batch;
	logic             last_of_run;

	modport source (output valid, command_word, words_in_batch, last_of_run, input ready);
	modport sink (input valid, command_word, words_in_batch, last_of_run, output ready);
endinterface

interface gce_cfg_if import gce_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/glyph_to_gpu_command_emitter.sv =====
// Channel  Dir  Carries                                                  Transfer when
// instr    in   opcode, dest_index, first_source, second_source,         valid && ready
//               program_start, program_end
// cmd      out  command_word, words_in_batch, last_of_run                valid && ready
// cfg      in   index (0 fill_color, 1 default_size), data               valid && ready
//
// One instruction per cycle while it emits no words. With cmd idle, the first word of a
// burst reaches cmd once the instruction has passed the stage 1 instruction register and
// been loaded into the stage 2 burst shift line.
// A burst leaves the output shift line word by word and waits while cmd holds ready low;
// it has up to 6 words for DRAW and up to 2 for HALT (fewer near capacity). The next
// instruction advances out of stage 1 in the cycle the burst's last word transfers.
// Reset clears register valid bits, batch state, halted flag and restores config.
// cfg is always ready; writes land at once.
module glyph_to_gpu_command_emitter import gce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gce_instr_if.sink  instr,
	gce_cmd_if.source  cmd,
	gce_cfg_if.sink    cfg
);

	burst_t burst;
	logic   burst_free;

	// stage 1: register read, ALU, batch bookkeeping, burst build
	gce_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr      (instr),
		.cfg        (cfg),
		.burst_free (burst_free),
		.burst      (burst)
	);

	// stage 2: burst shift line feeding the cmd channel
	gce_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst      (burst),
		.burst_free (burst_free),
		.cmd        (cmd)
	);

endmodule

// ===== design/gce_ram.sv =====
module gce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end

endmodule

// ===== design/gce_exec.sv =====
module gce_exec import gce_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gce_instr_if.sink instr,
	gce_cfg_if.sink   cfg,
	input  logic      burst_free,
	output burst_t    burst
);

	// stage 1 instruction register
	logic        v_s1;
	logic [7:0]  op_s1;
	logic [7:0]  d_s1;
	logic [7:0]  a_s1;
	logic [31:0] b_s1;
	logic        start_s1;
	logic        end_s1;

	// architectural state
	logic [CNT_W-1:0]    cnt_q;
	logic [31:0]         last_q;
	logic                halted_q;
	logic [NUM_REGS-1:0] vld_q;
	logic [31:0]         fill_q;
	logic [31:0]         dsize_q;

	// last register write, seen by the item read at the same edge
	logic              wb_valid_q;
	logic [REG_AW-1:0] wb_addr_q;
	logic [31:0]       wb_data_q;

	logic        adv;
	logic        acc;
	logic [31:0] rd0;
	logic [31:0] rd1;
	logic [31:0] ra;
	logic [31:0] rb;
	logic        wr_en;
	logic [31:0] wdata;
	logic [31:0] prod;

	logic [CNT_W-1:0]  count0;
	logic [31:0]       last0;
	logic              halted0;
	logic              active;
	logic              d_ok;
	logic              a_ok;
	logic              b_ok;
	logic              three_ok;
	logic [31:0]       side_raw;
	logic [31:0]       side;
	logic [31:0]       size_word;
	logic [NW_W-1:0]   n_ins;
	logic [31:0]       cand [MAX_WORDS];
	logic [CNT_W-1:0]  room;
	logic [NW_W-1:0]   keep1;
	logic [CNT_W-1:0]  count1;
	logic [31:0]       last1;
	logic              end_push;
	logic [NW_W-1:0]   n_tot;
	logic [SLOT_W-1:0] last_slot;

	assign adv         = v_s1 && burst_free;
	assign instr.ready = !v_s1 || burst_free;
	assign acc         = instr.valid && instr.ready;
	assign cfg.ready   = 1'b1;

	gce_ram #(
		.WIDTH (32),
		.DEPTH (NUM_REGS)
	) u_regs (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (d_s1[REG_AW-1:0]),
		.wdata  (wdata),
		.re     (acc),
		.raddr0 (instr.first_source[REG_AW-1:0]),
		.raddr1 (instr.second_source[REG_AW-1:0]),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	// operand select: forward, stored value, or zero for never-written
	always_comb begin
		if (wb_valid_q && wb_addr_q == a_s1[REG_AW-1:0]) begin
			ra = wb_data_q;
		end else begin
			ra = vld_q[a_s1[REG_AW-1:0]] ? rd0 : 32'd0;
		end
		if (wb_valid_q && wb_addr_q == b_s1[REG_AW-1:0]) begin
			rb = wb_data_q;
		end else begin
			rb = vld_q[b_s1[REG_AW-1:0]] ? rd1 : 32'd0;
		end
	end

	assign count0  = start_s1 ? '0 : cnt_q;
	assign last0   = start_s1 ? 32'd0 : last_q;
	assign halted0 = start_s1 ? 1'b0 : halted_q;
	assign active  = !halted0;

	assign d_ok     = d_s1[7:REG_AW] == '0;
	assign a_ok     = a_s1[7:REG_AW] == '0;
	assign b_ok     = b_s1[31:REG_AW] == '0;
	assign three_ok = d_ok && a_ok && b_ok;
	assign prod     = ra * rb;

	always_comb begin
		wr_en = 1'b0;
		wdata = b_s1;
		n_ins = '0;
		unique case (op_s1)
			OP_ADD: begin
				wr_en = three_ok;
				wdata = ra + rb;
			end
			OP_SUB: begin
				wr_en = three_ok;
				wdata = ra - rb;
			end
			OP_MUL: begin
				wr_en = three_ok;
				wdata = prod;
			end
			OP_MOV: begin
				wr_en = d_ok && a_ok;
				wdata = b_s1;
			end
			OP_DRAW: n_ins = NW_W'(5);
			OP_HALT: n_ins = NW_W'(2);
			default: begin
				wr_en = 1'b0;
			end
		endcase
		if (!active) begin
			wr_en = 1'b0;
			n_ins = '0;
		end
		wr_en = wr_en && adv;
	end

	assign side_raw  = b_ok ? rb : 32'd0;
	assign side      = (side_raw == 32'd0) ? dsize_q : side_raw;
	assign size_word = {side[15:0], 16'd0} | side;

	always_comb begin
		for (int i = 0; i < MAX_WORDS; i++) begin
			cand[i] = WORD_END;
		end
		if (op_s1 == OP_DRAW) begin
			cand[0] = WORD_BLIT;
			cand[1] = size_word;
			cand[2] = 32'd0;
			cand[3] = 32'd0;
			cand[4] = fill_q;
		end else if (op_s1 == OP_HALT) begin
			cand[0] = WORD_FLUSH;
		end
	end

	// words beyond the batch capacity are dropped from the tail
	assign room      = CNT_W'(BATCH_WORDS) - count0;
	assign keep1     = (room < CNT_W'(n_ins)) ? room[NW_W-1:0] : n_ins;
	assign count1    = count0 + CNT_W'(keep1);
	assign last_slot = SLOT_W'(keep1 - NW_W'(1));
	assign last1     = (keep1 == '0) ? last0 : cand[last_slot];
	assign end_push  = end_s1 && count1 != '0 && last1 != WORD_END
		&& count1 < CNT_W'(BATCH_WORDS);
	assign n_tot     = keep1 + NW_W'(end_push);

	always_comb begin
		burst.load = adv;
		burst.n    = n_tot;
		for (int i = 0; i < MAX_WORDS; i++) begin
			burst.words[i] = (NW_W'(i) < keep1) ? cand[i] : WORD_END;
			burst.wib[i]   = WIB_W'(count0 + CNT_W'(i + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			cnt_q      <= '0;
			last_q     <= 32'd0;
			halted_q   <= 1'b0;
			vld_q      <= '0;
			fill_q     <= FILL_COLOR_RST;
			dsize_q    <= DEFAULT_SIZE_RST;
			wb_valid_q <= 1'b0;
		end else begin
			if (instr.ready) begin
				v_s1 <= instr.valid;
			end
			if (adv) begin
				cnt_q    <= count1 + CNT_W'(end_push);
				last_q   <= end_push ? WORD_END : last1;
				halted_q <= halted0 || (active && op_s1 == OP_HALT);
			end
			if (wr_en) begin
				vld_q[d_s1[REG_AW-1:0]] <= 1'b1;
			end
			if (acc) begin
				wb_valid_q <= wr_en;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_FILL_COLOR:   fill_q  <= cfg.data;
					CFG_DEFAULT_SIZE: dsize_q <= cfg.data;
					default: begin
						fill_q <= fill_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1     <= instr.opcode;
			d_s1      <= instr.dest_index;
			a_s1      <= instr.first_source;
			b_s1      <= instr.second_source;
			start_s1  <= instr.program_start;
			end_s1    <= instr.program_end;
			wb_addr_q <= d_s1[REG_AW-1:0];
			wb_data_q <= wdata;
		end
	end

endmodule

// ===== design/gce_burst.sv =====
module gce_burst import gce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  burst_t     burst,
	output logic       burst_free,
	gce_cmd_if.source  cmd
);

	logic [NW_W-1:0]  cnt_s2;
	logic [31:0]      words_s2 [MAX_WORDS];
	logic [WIB_W-1:0] wib_s2 [MAX_WORDS];
	logic             xfer;

	assign cmd.valid          = cnt_s2 != '0;
	assign cmd.command_word   = words_s2[0];
	assign cmd.words_in_batch = wib_s2[0];
	assign cmd.last_of_run    = cnt_s2 == NW_W'(1);

	assign xfer       = cmd.valid && cmd.ready;
	assign burst_free = (cnt_s2 == '0) || (cnt_s2 == NW_W'(1) && cmd.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (burst.load) begin
			cnt_s2 <= burst.n;
		end else if (xfer) begin
			cnt_s2 <= cnt_s2 - NW_W'(1);
		end
	end

	// shift line: the head word always sits in slot 0
	always_ff @(posedge clk) begin
		if (burst.load) begin
			for (int i = 0; i < MAX_WORDS; i++) begin
				words_s2[i] <= burst.words[i];
				wib_s2[i]   <= burst.wib[i];
			end
		end else if (xfer) begin
			for (int i = 0; i < MAX_WORDS - 1; i++) begin
				words_s2[i] <= words_s2[i+1];
				wib_s2[i]   <= wib_s2[i+1];
			end
		end
	end

endmodule

// ===== design/gce_checker.sv =====
module gce_checker import gce_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             instr_valid,
	input logic             instr_ready,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input logic [31:0]      cmd_word,
	input logic [WIB_W-1:0] cmd_wib,
	input logic             cmd_last
);

	// stalled result holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_word) && $stable(cmd_wib))
		else $error("cmd payload changed under stall");

	a_wib_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> cmd_wib != '0)
		else $error("words_in_batch zero on a valid word");

	// words of one run follow back to back and count up by one
	a_run_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !cmd_last |=>
			cmd_valid && cmd_wib == WIB_W'($past(cmd_wib) + WIB_W'(1)))
		else $error("run words not consecutive");

	// an idle output wakes up only for an instruction taken earlier that passed through stage 1
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd_valid) |-> $past(instr_valid && instr_ready, 2))
		else $error("output woke without an instruction");

endmodule

bind glyph_to_gpu_command_emitter gce_checker u_gce_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.instr_valid (instr.valid),
	.instr_ready (instr.ready),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_word    (cmd.command_word),
	.cmd_wib     (cmd.words_in_batch),
	.cmd_last    (cmd.last_of_run)
);
